// ===== src/matrix_multiply_engine_macros.svh =====
// ---------------------------------------------------------------------------
// matrix multiply engine assertion macros
// checking helpers for the matrix_multiply_engine module
// ---------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// implication checked on every edge outside reset
`define MME_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every edge, reset included
`define MME_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/mme_pkg.sv =====
// ---------------------------------------------------------------------------
// mme_pkg
// shared types, constants and helpers of the matrix multiply engine
// ---------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 4;
  localparam int VAL_W     = 32;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = PROD_W + IDX_W;
  localparam int CFG_A_W   = 2;
  localparam int WAIT_CYC  = MAX_DIM + 2;
  localparam int WAIT_W    = $clog2(WAIT_CYC + 1);

  typedef enum logic [1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_START  = 2'd2
  } req_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FEED,
    S_WAIT,
    S_EMIT
  } state_t;

  // one word travelling along the cell chain
  typedef struct packed {
    logic                    vld;
    logic                    first;
    logic [IDX_W-1:0]        k;
    logic signed [VAL_W-1:0] a;
  } cell_bus_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             sat;
  } sat_res_t;

  // register value to last index, 0 acts as 1 and oversize as MAX_DIM
  function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] r;
    if (v == '0) r = '0;
    else if (v > DIM_W'(MAX_DIM)) r = IDX_W'(MAX_DIM - 1);
    else r = IDX_W'(v - DIM_W'(1));
    return r;
  endfunction

  // floor shift by the fraction width, then clip to 32 bits
  function automatic sat_res_t scale_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sat_res_t r;
    sh = acc >>> FRAC_BITS;
    if ((&sh[ACC_W-1:VAL_W-1]) || !(|sh[ACC_W-1:VAL_W-1])) begin
      r.value = sh[VAL_W-1:0];
      r.sat   = 1'b0;
    end else begin
      r.value = sh[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== src/mme_cell.sv =====
// ---------------------------------------------------------------------------
// mme_cell
// one result column: holds a column of B, multiplies the passing A element
// and accumulates at full precision, forwards the word to the next cell
// ---------------------------------------------------------------------------
module mme_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mme_pkg::cell_bus_t                cell_in,
  input  logic                              b_we,
  input  logic [mme_pkg::IDX_W-1:0]         b_addr,
  input  logic [mme_pkg::VAL_W-1:0]         b_data,
  output mme_pkg::cell_bus_t                cell_out,
  output logic signed [mme_pkg::ACC_W-1:0]  acc
);

  logic [mme_pkg::VAL_W-1:0]          b_col [mme_pkg::MAX_DIM];
  logic signed [mme_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic                               prod_vld_r, prod_first_r;
  logic signed [mme_pkg::ACC_W-1:0]   acc_r, acc_nxt, prod_ext;
  mme_pkg::cell_bus_t                 fwd_r;

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_col[b_addr] <= b_data;
    end
  end

  assign prod_nxt = $signed(cell_in.a) * $signed(b_col[cell_in.k]);
  assign prod_ext = {{(mme_pkg::ACC_W - mme_pkg::PROD_W){prod_r[mme_pkg::PROD_W-1]}}, prod_r};

  always_comb begin
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      acc_nxt = prod_first_r ? prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r   <= 1'b0;
      prod_first_r <= 1'b0;
      fwd_r        <= '0;
    end else begin
      prod_vld_r   <= cell_in.vld;
      prod_first_r <= cell_in.first;
      fwd_r        <= cell_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign cell_out = fwd_r;
  assign acc      = acc_r;

endmodule

// ===== src/matrix_multiply_engine.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply_engine
// dense Q16.16 matrix multiply over a chain of column cells
// ---------------------------------------------------------------------------
// Load words (A or B element) are taken one per cycle while idle. A start
// word takes the block busy: for each result row the A row is read from its
// memory one element a cycle and passed down a chain of MAX_DIM column
// cells, each holding one column of B; after the chain drains (S_WAIT) the
// row's cols_b results leave one per cycle through the output register
// while the output is not stalled.
// ---------------------------------------------------------------------------
`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mme_pkg::CFG_A_W-1:0]      cfg_addr,
  input  logic [mme_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_req_type,
  input  logic [mme_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mme_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [mme_pkg::VAL_W-1:0] in_elem_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mme_pkg::IDX_W-1:0]        out_row,
  output logic [mme_pkg::IDX_W-1:0]        out_col,
  output logic signed [mme_pkg::VAL_W-1:0] out_value,
  output logic                             out_saturated,
  output logic                             out_last
);

  logic [mme_pkg::DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic [mme_pkg::IDX_W-1:0] nr_m1, nk_m1, nc_m1;

  mme_pkg::state_t           state_r, state_nxt;
  logic [mme_pkg::IDX_W-1:0] i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [mme_pkg::WAIT_W-1:0] wait_r, wait_nxt;

  logic [mme_pkg::VAL_W-1:0] a_mem [mme_pkg::DEPTH];
  logic [mme_pkg::VAL_W-1:0] a_rd_r;
  logic                      feed, feed_vld_r, feed_first_r;
  logic [mme_pkg::IDX_W-1:0] feed_k_r;

  mme_pkg::cell_bus_t               chain [mme_pkg::MAX_DIM+1];
  logic signed [mme_pkg::ACC_W-1:0] acc_a [mme_pkg::MAX_DIM];

  logic                      in_acc, out_free, emit;
  mme_pkg::sat_res_t         res;
  logic                      out_vld_r;
  logic [mme_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic [mme_pkg::VAL_W-1:0] out_value_r;
  logic                      out_sat_r, out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= mme_pkg::DIM_W'(4);
      inner_dim_r <= mme_pkg::DIM_W'(4);
      cols_b_r    <= mme_pkg::DIM_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mme_pkg::REG_ROWS_A:    rows_a_r    <= cfg_wdata;
        mme_pkg::REG_INNER_DIM: inner_dim_r <= cfg_wdata;
        mme_pkg::REG_COLS_B:    cols_b_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nr_m1 = mme_pkg::dim_last(rows_a_r);
  assign nk_m1 = mme_pkg::dim_last(inner_dim_r);
  assign nc_m1 = mme_pkg::dim_last(cols_b_r);

  assign in_stall = (state_r != mme_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  // A element store
  always_ff @(posedge clk) begin
    if (in_acc && in_req_type == mme_pkg::REQ_LOAD_A) begin
      a_mem[{in_row_index, in_col_index}] <= in_elem_value;
    end
  end

  always_ff @(posedge clk) begin
    a_rd_r <= a_mem[{i_r, k_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feed_vld_r   <= 1'b0;
      feed_first_r <= 1'b0;
      feed_k_r     <= '0;
    end else begin
      feed_vld_r   <= feed;
      feed_first_r <= feed && (k_r == '0);
      feed_k_r     <= k_r;
    end
  end

  assign chain[0] = '{vld: feed_vld_r, first: feed_first_r, k: feed_k_r, a: a_rd_r};

  for (genvar c = 0; c < mme_pkg::MAX_DIM; c++) begin : g_cell
    mme_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[c]),
      .b_we     (in_acc && in_req_type == mme_pkg::REQ_LOAD_B &&
                 in_col_index == mme_pkg::IDX_W'(c)),
      .b_addr   (in_row_index),
      .b_data   (in_elem_value),
      .cell_out (chain[c+1]),
      .acc      (acc_a[c])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
      i_r     <= '0;
      k_r     <= '0;
      j_r     <= '0;
      wait_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    wait_nxt  = wait_r;
    feed      = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      mme_pkg::S_IDLE: begin
        if (in_acc && in_req_type == mme_pkg::REQ_START) begin
          state_nxt = mme_pkg::S_FEED;
          i_nxt     = '0;
          k_nxt     = '0;
          j_nxt     = '0;
        end
      end
      mme_pkg::S_FEED: begin
        feed = 1'b1;
        if (k_r == nk_m1) begin
          k_nxt     = '0;
          wait_nxt  = '0;
          state_nxt = mme_pkg::S_WAIT;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      mme_pkg::S_WAIT: begin
        // let the last element ripple through every cell
        if (wait_r == mme_pkg::WAIT_W'(mme_pkg::WAIT_CYC - 1)) begin
          state_nxt = mme_pkg::S_EMIT;
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      mme_pkg::S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (j_r == nc_m1) begin
            j_nxt = '0;
            if (i_r == nr_m1) begin
              state_nxt = mme_pkg::S_IDLE;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = mme_pkg::S_FEED;
            end
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: state_nxt = mme_pkg::S_IDLE;
    endcase
  end

  assign res = mme_pkg::scale_sat(acc_a[j_r]);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row_r   <= i_r;
      out_col_r   <= j_r;
      out_value_r <= res.value;
      out_sat_r   <= res.sat;
      out_last_r  <= (i_r == nr_m1) && (j_r == nc_m1);
    end
  end

  assign out_valid     = out_vld_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;
  assign out_last      = out_last_r;

  `MME_ASSERT(a_start_feeds,
    in_acc && in_req_type == mme_pkg::REQ_START |=>
      state_r == mme_pkg::S_FEED && i_r == '0 && k_r == '0,
    "start word did not begin a feed at row 0")
  `MME_ASSERT(a_chain_drained,
    state_r == mme_pkg::S_EMIT |-> !chain[mme_pkg::MAX_DIM].vld && !feed_vld_r,
    "results read before the cell chain drained")
  `MME_ASSERT(a_k_bound, state_r == mme_pkg::S_FEED |-> k_r <= nk_m1,
    "inner index past inner_dim")
  `MME_ASSERT_ALWAYS(a_no_emit_unless_free, emit |-> out_free,
    "output register overwritten while held")

endmodule
